// ===== hw/rtl/cqat_pkg.sv =====
package cqat_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_PUT  = 2'd0;
    localparam logic [1:0] KIND_POLL = 2'd1;
    localparam logic [1:0] KIND_LINE = 2'd2;

    localparam logic [1:0] LC_OTHER   = 2'd0;
    localparam logic [1:0] LC_OK      = 2'd1;
    localparam logic [1:0] LC_SEND_OK = 2'd2;
    localparam logic [1:0] LC_READY   = 2'd3;

    localparam logic [2:0] ST_DISCONNECTED = 3'd0;
    localparam logic [2:0] ST_CONNECTED    = 3'd1;
    localparam logic [2:0] ST_READY        = 3'd2;
    localparam logic [2:0] ST_WAITING      = 3'd3;
    localparam logic [2:0] ST_GOT_OK       = 3'd4;
    localparam logic [2:0] ST_TIMEOUT      = 3'd5;

    localparam logic [1:0] RK_PUT    = 2'd0;
    localparam logic [1:0] RK_NOTICE = 2'd1;
    localparam logic [1:0] RK_STATUS = 2'd2;

    localparam logic [7:0] TIMEOUT_RESET = 8'd10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] command_handle;
        logic [1:0]  line_class;
        logic [5:0]  current_second;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  protocol_state;
        logic        accepted;
        logic        send_valid;
        logic [15:0] sent_handle;
    } res_t;

    typedef struct packed {
        logic [1:0]      count;
        res_t [2:0]      res;
    } batch_t;

endpackage

// ===== hw/rtl/cqat_ctrl.sv =====
module cqat_ctrl
    import cqat_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wen,
    input  logic [7:0] cfg_wdata,
    input  logic       item_en,
    input  in_item_t   item,
    output batch_t     batch
);

    logic [15:0]      store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       link_reg, link_next;
    logic [5:0]       prev_sec_reg, prev_sec_next;
    logic [7:0]       wait_reg, wait_next;
    logic [15:0]      cur_handle_reg, cur_handle_next;
    logic [7:0]       timeout_reg;

    logic             q_full;
    logic             do_put;
    logic             issue;
    logic             sec_change;
    logic [2:0]       mid_state;
    logic [7:0]       wait_inc;
    logic             time_out;
    logic [1:0]       n;

    assign q_full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign do_put     = (item.kind == KIND_PUT) && !q_full;
    assign issue      = (item.kind == KIND_POLL) && (link_reg == ST_READY) &&
                        (cnt_reg != '0);
    assign sec_change = (item.kind == KIND_POLL) && (item.current_second != prev_sec_reg);
    assign mid_state  = issue ? ST_WAITING : link_reg;
    assign wait_inc   = (wait_reg == 8'hFF) ? wait_reg : wait_reg + 8'd1;
    assign time_out   = sec_change && (mid_state == ST_WAITING) && (wait_inc >= timeout_reg);

    always_comb begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        cnt_next        = cnt_reg;
        link_next       = link_reg;
        prev_sec_next   = prev_sec_reg;
        wait_next       = wait_reg;
        cur_handle_next = cur_handle_reg;
        batch           = '0;
        n               = 2'd0;

        case (item.kind)
            KIND_PUT: begin
                if (do_put) begin
                    wp_next  = (wp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                batch.res[0].result_kind    = RK_PUT;
                batch.res[0].protocol_state = link_reg;
                batch.res[0].accepted       = do_put;
                n = 2'd1;
            end
            KIND_POLL: begin
                if (issue) begin
                    cur_handle_next = store_reg[rp_reg];
                    rp_next  = (rp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    link_next = ST_WAITING;
                    batch.res[0].result_kind    = RK_NOTICE;
                    batch.res[0].protocol_state = ST_WAITING;
                    batch.res[0].send_valid     = 1'b1;
                    batch.res[0].sent_handle    = store_reg[rp_reg];
                    n = 2'd1;
                end
                if (sec_change) begin
                    prev_sec_next = item.current_second;
                    if (mid_state == ST_WAITING) begin
                        wait_next = wait_inc;
                        if (time_out) begin
                            wait_next = '0;
                            link_next = ST_READY;
                            batch.res[n].result_kind           = RK_NOTICE;
                            batch.res[n].protocol_state        = ST_TIMEOUT;
                            batch.res[n + 2'd1].result_kind    = RK_NOTICE;
                            batch.res[n + 2'd1].protocol_state = ST_READY;
                            n = n + 2'd2;
                        end
                    end else begin
                        wait_next = '0;
                    end
                end
            end
            KIND_LINE: begin
                if (link_reg == ST_WAITING && item.line_class != LC_OTHER) begin
                    link_next = ST_READY;
                    batch.res[0].result_kind    = RK_NOTICE;
                    batch.res[0].protocol_state =
                        (item.line_class == LC_READY) ? ST_CONNECTED : ST_GOT_OK;
                    batch.res[1].result_kind    = RK_NOTICE;
                    batch.res[1].protocol_state = ST_READY;
                    n = 2'd2;
                end
            end
            default: begin
            end
        endcase

        if (n == 2'd0) begin
            batch.res[0].result_kind    = RK_STATUS;
            batch.res[0].protocol_state = link_reg;
            n = 2'd1;
        end
        batch.count = n;
    end

    always_ff @(posedge aclk) begin
        if (item_en && do_put) begin
            store_reg[wp_reg] <= item.command_handle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg         <= '0;
            rp_reg         <= '0;
            cnt_reg        <= '0;
            link_reg       <= ST_READY;
            prev_sec_reg   <= '0;
            wait_reg       <= '0;
            cur_handle_reg <= '0;
        end else if (item_en) begin
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            cnt_reg        <= cnt_next;
            link_reg       <= link_next;
            prev_sec_reg   <= prev_sec_next;
            wait_reg       <= wait_next;
            cur_handle_reg <= cur_handle_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wen) begin
            timeout_reg <= cfg_wdata;
        end
    end

endmodule

// ===== hw/rtl/command_queue_ack_timeout_sequencer_top.sv =====
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tuser kind, s_tdata handle/class/second
// m_        out  m_tvalid/m_tready    m_tuser result kind, m_tdata, m_tlast
// cfg_      in   cfg_wen              cfg_wdata timeout in seconds
//
// An item is worked in the cycle it is accepted and gives one to three results,
// which leave the result buffer at one per cycle while m_tready is high: one
// result for a put, up to three for a poll tick.
// The next item is accepted in the cycle its predecessor's last result is taken.
// Reset is synchronous and active low: queue empty, state ready, timeout 10.
// While m_tready is low the buffered results hold and, while any are buffered, s_tready stays low.
module command_queue_ack_timeout_sequencer_top
    import cqat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // command_handle, line_class, current_second
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // protocol_state, accepted, send_valid, sent_handle
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata
);

    in_item_t   item;
    batch_t     batch;
    logic       item_en;
    logic       pop;
    res_t [2:0] ob_reg;
    logic [1:0] ocnt_reg, ocnt_next;

    assign item.kind           = s_tuser;
    assign item.command_handle = s_tdata[15:0];
    assign item.line_class     = s_tdata[17:16];
    assign item.current_second = s_tdata[23:18];

    assign m_tvalid = (ocnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (ocnt_reg == 2'd0) || ((ocnt_reg == 2'd1) && m_tready);
    assign item_en  = s_tvalid && s_tready;

    cqat_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .item_en   (item_en),
        .item      (item),
        .batch     (batch)
    );

    always_comb begin
        ocnt_next = ocnt_reg;
        if (item_en) begin
            ocnt_next = batch.count;
        end else if (pop) begin
            ocnt_next = ocnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_en) begin
            ob_reg <= batch.res;
        end else if (pop) begin
            ob_reg[0] <= ob_reg[1];
            ob_reg[1] <= ob_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocnt_reg <= '0;
        end else begin
            ocnt_reg <= ocnt_next;
        end
    end

    assign m_tuser = ob_reg[0].result_kind;
    assign m_tlast = (ocnt_reg == 2'd1);
    assign m_tdata = {3'b000, ob_reg[0].sent_handle, ob_reg[0].send_valid,
                      ob_reg[0].accepted, ob_reg[0].protocol_state};

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("Accepted item gave no result.");

    a_put_single_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_PUT) |=>
        (m_tlast && m_tuser == RK_PUT))
        else $error("Put item did not give a single put answer.");

    a_send_is_wait_notice: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4]) |->
        (m_tuser == RK_NOTICE && m_tdata[2:0] == ST_WAITING))
        else $error("Command issued outside a waiting notice.");

endmodule

// ===== tb/sv/command_queue_ack_timeout_sequencer_top_tb.sv =====
module command_queue_ack_timeout_sequencer_top_tb;
    import cqat_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 24;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [1:0]  rkind;
        logic [2:0]  state;
        logic        acc;
        logic        snd;
        logic [15:0] handle;
        logic        last;
    } seq_result_t;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  kind;
        logic [15:0] handle;
        logic [1:0]  cls;
        logic [5:0]  sec;
        logic [7:0]  cfg_val;
        logic        typed;
        logic [1:0]  t_kind;
        logic [2:0]  t_state;
        logic        t_acc;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wen;
    logic [7:0]  cfg_wdata;

    logic [15:0]      handle_ring [QUEUE_DEPTH];
    logic [PTR_W-1:0] ring_wr = '0;
    logic [PTR_W-1:0] ring_rd = '0;
    logic [CNT_W-1:0] ring_fill = '0;
    logic [2:0]       link_st = ST_READY;
    logic [5:0]       seen_second = '0;
    logic [7:0]       wait_secs = '0;
    logic [15:0]      issued_handle = '0;
    logic [7:0]       timeout_secs = TIMEOUT_RESET;

    seq_result_t pending_results[$];
    int          errors = 0;
    bit          hold_request = 1'b0;
    bit          calm = 1'b0;

    stim_row_t directed_rows [0:27] = '{
        '{1'b0, KIND_POLL,   16'h0000, LC_OTHER,   6'd0,  8'd0,  1'b1, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_LINE,   16'h0000, LC_OK,      6'd0,  8'd0,  1'b1, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_LINE,   16'h0000, LC_READY,   6'd0,  8'd0,  1'b1, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_UNUSED, 16'hFFFF, LC_READY,   6'd63, 8'd0,  1'b1, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_PUT,    16'h0000, LC_OTHER,   6'd0,  8'd0,  1'b1, RK_PUT,    ST_READY, 1'b1},
        '{1'b0, KIND_PUT,    16'hFFFF, LC_READY,   6'd63, 8'd0,  1'b1, RK_PUT,    ST_READY, 1'b1},
        '{1'b0, KIND_PUT,    16'hAAAA, LC_SEND_OK, 6'd42, 8'd0,  1'b1, RK_PUT,    ST_READY, 1'b1},
        '{1'b0, KIND_PUT,    16'h5555, LC_OK,      6'd21, 8'd0,  1'b1, RK_PUT,    ST_READY, 1'b1},
        '{1'b0, KIND_PUT,    16'h0001, LC_OTHER,   6'd0,  8'd0,  1'b1, RK_PUT,    ST_READY, 1'b1},
        '{1'b0, KIND_PUT,    16'h0002, LC_OTHER,   6'd0,  8'd0,  1'b1, RK_PUT,    ST_READY, 1'b1},
        '{1'b0, KIND_PUT,    16'h0003, LC_OTHER,   6'd0,  8'd0,  1'b1, RK_PUT,    ST_READY, 1'b1},
        '{1'b0, KIND_PUT,    16'h0004, LC_OTHER,   6'd0,  8'd0,  1'b1, RK_PUT,    ST_READY, 1'b1},
        '{1'b0, KIND_PUT,    16'h1234, LC_OTHER,   6'd0,  8'd0,  1'b1, RK_PUT,    ST_READY, 1'b0},
        '{1'b0, KIND_POLL,   16'h0000, LC_OTHER,   6'd0,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_LINE,   16'h0000, LC_OTHER,   6'd0,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_PUT,    16'h4321, LC_OTHER,   6'd0,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_LINE,   16'h0000, LC_OK,      6'd0,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_POLL,   16'h0000, LC_OTHER,   6'd0,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_LINE,   16'h0000, LC_SEND_OK, 6'd0,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_POLL,   16'h0000, LC_OTHER,   6'd0,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_LINE,   16'h0000, LC_READY,   6'd0,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_POLL,   16'h0000, LC_OTHER,   6'd63, 8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b1, KIND_PUT,    16'h0000, LC_OTHER,   6'd0,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_POLL,   16'h0000, LC_OTHER,   6'd5,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_POLL,   16'h0000, LC_OTHER,   6'd5,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_POLL,   16'h0000, LC_OTHER,   6'd6,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b0, KIND_POLL,   16'h0000, LC_OTHER,   6'd7,  8'd0,  1'b0, RK_STATUS, ST_READY, 1'b0},
        '{1'b1, KIND_PUT,    16'h0000, LC_OTHER,   6'd0,  8'd10, 1'b0, RK_STATUS, ST_READY, 1'b0}
    };

    logic [7:0] timeout_plan [0:4] = '{8'd3, 8'd1, 8'd255, 8'd2, 8'd4};

    command_queue_ack_timeout_sequencer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic seq_result_t make_result(input logic [1:0] rk, input logic [2:0] st,
                                                input logic acc, input logic snd,
                                                input logic [15:0] h);
        seq_result_t r;
        r.rkind  = rk;
        r.state  = st;
        r.acc    = acc;
        r.snd    = snd;
        r.handle = h;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic void advance_sequencer(input logic [1:0] kind, input logic [15:0] handle,
                                              input logic [1:0] cls, input logic [5:0] sec,
                                              output seq_result_t produced[$]);
        seq_result_t tail;
        produced = {};
        if (kind == KIND_PUT) begin
            if (ring_fill < QUEUE_DEPTH) begin
                handle_ring[ring_wr] = handle;
                ring_wr = ring_wr + 1'b1;
                ring_fill = ring_fill + 1'b1;
                produced.push_back(make_result(RK_PUT, link_st, 1'b1, 1'b0, 16'h0000));
            end else begin
                produced.push_back(make_result(RK_PUT, link_st, 1'b0, 1'b0, 16'h0000));
            end
        end else if (kind == KIND_POLL) begin
            if (link_st == ST_READY && ring_fill != 0) begin
                issued_handle = handle_ring[ring_rd];
                ring_rd = ring_rd + 1'b1;
                ring_fill = ring_fill - 1'b1;
                link_st = ST_WAITING;
                produced.push_back(make_result(RK_NOTICE, ST_WAITING, 1'b0, 1'b1, issued_handle));
            end
            if (sec != seen_second) begin
                seen_second = sec;
                if (link_st == ST_WAITING) begin
                    if (wait_secs != 8'd255) begin
                        wait_secs = wait_secs + 1'b1;
                    end
                    if (wait_secs >= timeout_secs) begin
                        wait_secs = '0;
                        link_st = ST_READY;
                        produced.push_back(make_result(RK_NOTICE, ST_TIMEOUT, 1'b0, 1'b0, 16'h0));
                        produced.push_back(make_result(RK_NOTICE, ST_READY, 1'b0, 1'b0, 16'h0));
                    end
                end else begin
                    wait_secs = '0;
                end
            end
        end else if (kind == KIND_LINE && link_st == ST_WAITING) begin
            if (cls == LC_OK || cls == LC_SEND_OK) begin
                link_st = ST_READY;
                produced.push_back(make_result(RK_NOTICE, ST_GOT_OK, 1'b0, 1'b0, 16'h0));
                produced.push_back(make_result(RK_NOTICE, ST_READY, 1'b0, 1'b0, 16'h0));
            end else if (cls == LC_READY) begin
                link_st = ST_READY;
                produced.push_back(make_result(RK_NOTICE, ST_CONNECTED, 1'b0, 1'b0, 16'h0));
                produced.push_back(make_result(RK_NOTICE, ST_READY, 1'b0, 1'b0, 16'h0));
            end
        end
        if (produced.size() == 0) begin
            produced.push_back(make_result(RK_STATUS, link_st, 1'b0, 1'b0, 16'h0));
        end
        tail = produced.pop_back();
        tail.last = 1'b1;
        produced.push_back(tail);
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic feed_item(input logic [1:0] kind, input logic [15:0] handle,
                             input logic [1:0] cls, input logic [5:0] sec,
                             input logic typed, input seq_result_t typed_result);
        seq_result_t produced[$];
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {sec, cls, handle};
        do @(posedge aclk); while (!s_tready);
        advance_sequencer(kind, handle, cls, sec, produced);
        if (typed) begin
            pending_results.push_back(typed_result);
        end else begin
            foreach (produced[i]) pending_results.push_back(produced[i]);
        end
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [7:0] value);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        timeout_secs = value;
    endtask

    always @(posedge aclk) begin
        seq_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d data %h last %b",
                         $time, m_tuser, m_tdata, m_tlast);
            end else begin
                want = pending_results.pop_front();
                compare_field("result_kind", want.rkind, m_tuser);
                compare_field("protocol_state", want.state, m_tdata[2:0]);
                compare_field("accepted", want.acc, m_tdata[3]);
                compare_field("send_valid", want.snd, m_tdata[4]);
                compare_field("sent_handle", want.handle, m_tdata[20:5]);
                compare_field("last", want.last, m_tlast);
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        seq_result_t typed_result;
        logic [1:0]  kind;
        logic [5:0]  sec;
        int          pick;
        int          waited;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_PUT;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_timeout(directed_rows[i].cfg_val);
            end else begin
                typed_result = make_result(directed_rows[i].t_kind, directed_rows[i].t_state,
                                           directed_rows[i].t_acc, 1'b0, 16'h0000);
                typed_result.last = 1'b1;
                feed_item(directed_rows[i].kind, directed_rows[i].handle, directed_rows[i].cls,
                          directed_rows[i].sec, directed_rows[i].typed, typed_result);
                sender_gap();
            end
        end

        sec = seen_second;
        for (int phase = 0; phase < 6; phase++) begin
            write_timeout(phase < 5 ? timeout_plan[phase] : TIMEOUT_RESET);
            if (phase == 1) begin
                hold_request = 1'b1;
            end
            if (phase == 5) begin
                calm = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 2 && n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    kind = KIND_PUT;
                end else if (pick < 70) begin
                    kind = KIND_POLL;
                end else if (pick < 95) begin
                    kind = KIND_LINE;
                end else begin
                    kind = KIND_UNUSED;
                end
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    sec = (sec >= 6'd59) ? 6'd0 : sec + 1'b1;
                end else if (pick < 55) begin
                    sec = 6'($urandom_range(0, 63));
                end
                feed_item(kind, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)), sec,
                          1'b0, typed_result);
                sender_gap();
            end
        end

        s_tvalid <= 1'b0;
        for (waited = 0; waited < 5000 && pending_results.size() != 0; waited++) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, pending_results.size());
        end
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cqat_pkg.sv
hw/rtl/cqat_ctrl.sv
hw/rtl/command_queue_ack_timeout_sequencer_top.sv
tb/sv/command_queue_ack_timeout_sequencer_top_tb.sv
